@@ rtl/core/pshp_pkg.sv @@
`timescale 1ns / 1ps

package pshp_pkg;

  localparam int unsigned HDR_LEN     = 9;
  localparam int unsigned HDR_IDX_W   = $clog2(HDR_LEN);
  localparam int unsigned CNT_W       = 13;
  localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] MIN_SECTION = 13'd13;
  localparam logic [CNT_W-1:0] LEN_OVERHEAD = 13'd3;
  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [7:0]  LEN_HI_MASK  = 8'h0F;
  localparam logic [7:0]  VER_MASK     = 8'h1F;
  localparam logic [7:0]  CUR_MASK     = 8'h01;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_LEN_ERR  = 2'd1,
    STATUS_CRC_ERR  = 2'd2
  } status_t;

  // one byte moving from the input register into the section state
  typedef struct packed {
    logic       adv;
    logic       last;
    logic [7:0] data;
  } step_t;

  typedef struct packed {
    logic [7:0]  table_kind;
    logic [11:0] body_length;
    logic [15:0] id_extension;
    logic [4:0]  version;
    logic        current_flag;
    logic [7:0]  section_index;
    logic [7:0]  last_section_index;
    logic [7:0]  protocol_level;
  } hdr_fields_t;

  // msb-first crc-32, one byte, no reflection
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/core/pshp_if.sv @@
`timescale 1ns / 1ps

interface pshp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pshp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  table_kind;
  logic [11:0] body_length;
  logic [15:0] id_extension;
  logic [4:0]  version;
  logic        current_flag;
  logic [7:0]  section_index;
  logic [7:0]  last_section_index;
  logic [7:0]  protocol_level;
  logic [1:0]  status;

  modport source (output valid, output table_kind, output body_length,
                  output id_extension, output version, output current_flag,
                  output section_index, output last_section_index,
                  output protocol_level, output status, input ready);
  modport sink   (input valid, input table_kind, input body_length,
                  input id_extension, input version, input current_flag,
                  input section_index, input last_section_index,
                  input protocol_level, input status, output ready);
endinterface

@@ rtl/core/pshp_crc.sv @@
`timescale 1ns / 1ps

module pshp_crc (
  input  logic           clk,
  input  logic           rst_n,
  input  pshp_pkg::step_t step,
  output logic [31:0]    crc_q,
  output logic           crc_zero
);

  logic [31:0] crc_r;
  logic [31:0] crc_upd;
  logic [31:0] crc_nxt;

  assign crc_upd  = pshp_pkg::crc32_byte(crc_r, step.data);
  assign crc_zero = (crc_upd == 32'h0);
  assign crc_q    = crc_r;

  // back to the initial value once the last byte is consumed
  always_comb begin
    crc_nxt = crc_r;
    if (step.adv) begin
      crc_nxt = step.last ? pshp_pkg::CRC_INIT : crc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= pshp_pkg::CRC_INIT;
    end else begin
      crc_r <= crc_nxt;
    end
  end

endmodule

@@ rtl/core/pshp_hdr.sv @@
`timescale 1ns / 1ps

module pshp_hdr (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pshp_pkg::step_t               step,
  output pshp_pkg::hdr_fields_t         fields,
  output logic [pshp_pkg::CNT_W-1:0]    count_upd,
  output logic [pshp_pkg::CNT_W-1:0]    count_q
);

  logic [7:0]                 hdr_r   [pshp_pkg::HDR_LEN];
  logic [7:0]                 hdr_upd [pshp_pkg::HDR_LEN];
  logic [7:0]                 hdr_nxt [pshp_pkg::HDR_LEN];
  logic [pshp_pkg::CNT_W-1:0] count_r;
  logic [pshp_pkg::CNT_W-1:0] count_nxt;
  logic                       in_hdr;

  assign in_hdr  = (count_r < pshp_pkg::CNT_W'(pshp_pkg::HDR_LEN));
  assign count_q = count_r;

  always_comb begin
    for (int i = 0; i < pshp_pkg::HDR_LEN; i++) begin
      hdr_upd[i] = hdr_r[i];
    end
    if (in_hdr) begin
      hdr_upd[count_r[pshp_pkg::HDR_IDX_W-1:0]] = step.data;
    end
  end

  // saturating byte count including the current byte
  assign count_upd = (count_r == pshp_pkg::CNT_MAX) ? count_r
                                                    : count_r + 1'b1;

  always_comb begin
    count_nxt = count_r;
    for (int i = 0; i < pshp_pkg::HDR_LEN; i++) begin
      hdr_nxt[i] = hdr_r[i];
    end
    if (step.adv) begin
      if (step.last) begin
        count_nxt = '0;
        for (int i = 0; i < pshp_pkg::HDR_LEN; i++) begin
          hdr_nxt[i] = 8'h0;
        end
      end else begin
        count_nxt = count_upd;
        for (int i = 0; i < pshp_pkg::HDR_LEN; i++) begin
          hdr_nxt[i] = hdr_upd[i];
        end
      end
    end
  end

  always_comb begin
    fields.table_kind         = hdr_upd[0];
    fields.body_length        = {hdr_upd[1][3:0] & pshp_pkg::LEN_HI_MASK[3:0], hdr_upd[2]};
    fields.id_extension       = {hdr_upd[3], hdr_upd[4]};
    fields.version            = hdr_upd[5][5:1] & pshp_pkg::VER_MASK[4:0];
    fields.current_flag       = hdr_upd[5][0] & pshp_pkg::CUR_MASK[0];
    fields.section_index      = hdr_upd[6];
    fields.last_section_index = hdr_upd[7];
    fields.protocol_level     = hdr_upd[8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < pshp_pkg::HDR_LEN; i++) begin
        hdr_r[i] <= 8'h0;
      end
    end else begin
      count_r <= count_nxt;
      for (int i = 0; i < pshp_pkg::HDR_LEN; i++) begin
        hdr_r[i] <= hdr_nxt[i];
      end
    end
  end

endmodule

@@ rtl/core/psi_section_header_parser_crc.sv @@
`timescale 1ns / 1ps

// table section header parser with crc-32 check
//
// in_ch carries one section byte per item, starting at the table id byte,
// with last_byte high on the final byte. out_ch gives one item per section,
// produced by the last byte: the header fields (bytes 0 to 8) and a status
// of ok, length mismatch (fewer than 13 bytes, or count != length + 3) or
// crc failure (nonzero mpeg-2 crc-32 remainder over the whole section).
//
// path: a byte is first held in the input register; when it leaves it, the
// section state and the result register update together, so the result
// is registered as the last byte leaves. throughput: one byte per cycle,
// set by the byte-wide crc update between the input register and the crc
// register, except while a last byte waits for the result register.
//
// reset (rst_n low, synchronous) clears the byte count and header bytes,
// presets the crc to all ones and drops both valids. when the receiver
// stalls, the result is held in the output register; bytes that are not
// last still flow, and a last byte waits in the input register until the
// result register frees up, so in_ch.ready drops only then.

module psi_section_header_parser_crc (
  input  logic              clk,
  input  logic              rst_n,
  pshp_in_if.sink           in_ch,
  pshp_out_if.source        out_ch
);

  // input register
  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic [7:0] s1_data_r;
  logic       s1_last_r;
  logic       s1_adv;

  pshp_pkg::step_t step;

  // section state outputs
  pshp_pkg::hdr_fields_t         fields;
  logic [pshp_pkg::CNT_W-1:0]    count_upd;
  logic [pshp_pkg::CNT_W-1:0]    count_q;
  logic [31:0]                   crc_q;
  logic                          crc_zero;
  logic [pshp_pkg::CNT_W-1:0]    expect_len;
  pshp_pkg::status_t             status;

  // result register
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  pshp_pkg::hdr_fields_t out_fields_r;
  pshp_pkg::status_t     out_status_r;

  // a non-last byte never needs the result register
  assign s1_adv = s1_valid_r && (!s1_last_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  assign s1_valid_nxt = in_ch.valid ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_ch.ready ? s1_valid_nxt : s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_data_r <= in_ch.data_byte;
      s1_last_r <= in_ch.last_byte;
    end
  end

  assign step.adv  = s1_adv;
  assign step.last = s1_last_r;
  assign step.data = s1_data_r;

  pshp_hdr u_hdr (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .fields    (fields),
    .count_upd (count_upd),
    .count_q   (count_q)
  );

  pshp_crc u_crc (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .crc_q    (crc_q),
    .crc_zero (crc_zero)
  );

  // length check wins over the crc check
  assign expect_len = {1'b0, fields.body_length} + pshp_pkg::LEN_OVERHEAD;

  always_comb begin
    priority if (count_upd < pshp_pkg::MIN_SECTION || count_upd != expect_len) begin
      status = pshp_pkg::STATUS_LEN_ERR;
    end else if (!crc_zero) begin
      status = pshp_pkg::STATUS_CRC_ERR;
    end else begin
      status = pshp_pkg::STATUS_OK;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (s1_adv && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_fields_r <= fields;
      out_status_r <= status;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.table_kind         = out_fields_r.table_kind;
  assign out_ch.body_length        = out_fields_r.body_length;
  assign out_ch.id_extension       = out_fields_r.id_extension;
  assign out_ch.version            = out_fields_r.version;
  assign out_ch.current_flag       = out_fields_r.current_flag;
  assign out_ch.section_index      = out_fields_r.section_index;
  assign out_ch.last_section_index = out_fields_r.last_section_index;
  assign out_ch.protocol_level     = out_fields_r.protocol_level;
  assign out_ch.status             = out_status_r;

  // a consumed last byte always leaves a result behind
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> out_valid_r)
    else $error("last byte consumed without a result");

  // section state is back at reset after the last byte
  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> (count_q == '0) && (crc_q == pshp_pkg::CRC_INIT))
    else $error("section state not cleared after last byte");

  // input side only stalls on a last byte waiting for the result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r && s1_last_r && out_valid_r && !out_ch.ready)
    else $error("input stalled without a blocked last byte");

endmodule
